>>> rtl/core/mrlp_pkg.sv
// Package for the modem response line parser: sizes, line kinds, character codes
// and the controller state type. Used by every module of the block.
package mrlp_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int NUMBER_MAX = 16;
    localparam int CHAR_CAP = 25;
    localparam int NUM_CAP = (NUMBER_MAX < CHAR_CAP) ? NUMBER_MAX : CHAR_CAP;
    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int FILL_W = $clog2(LINE_DEPTH + 1);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    typedef enum logic [2:0] {
        KIND_OTHER  = 3'd0,
        KIND_OK     = 3'd1,
        KIND_CALLER = 3'd2,
        KIND_SLOT   = 3'd3,
        KIND_SIGNAL = 3'd4,
        KIND_CMD    = 3'd5,
        KIND_SENDER = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_SEARCH,
        ST_COPY,
        ST_DONE
    } state_t;

endpackage

>>> rtl/core/modem_response_line_parser_unit.sv
// Top level of the modem response line parser: byte intake, line store and
// the line-end scanner. Depends on mrlp_pkg and mrlp_line_ram.
//
// Ordinary bytes are taken one per cycle while idle and written into the
// line store, up to 63 per line. When a line feed completes a line, the
// block stops taking input until the line has been reported. It then reads
// the store one byte at a time: for each byte it issues the read and then
// uses the registered data. It sends a header item, then the extracted
// characters, and marks the final item with tlast. The longest scan is a
// sender line: 20 search positions, 16 characters and the stopping byte.
// The scan also waits whenever the receiver holds off tready.
module modem_response_line_parser_unit
    import mrlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // rx_byte[7:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // field_char[7:0]
    output logic [3:0] m_tuser,   // line_kind[2:0], char_valid[3]
    output logic       m_tlast    // last_of_line
);

    state_t state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic line_open_reg, line_open_next;
    kind_t kind_reg, kind_next;
    logic [ADDR_W:0] pos_reg, pos_next;
    logic [4:0] cnt_reg, cnt_next;
    logic pend_reg, pend_next;           // read data for pos_reg is valid
    logic [7:0] hdr_reg [5];
    logic [7:0] rdata;
    logic [ADDR_W-1:0] raddr;
    logic we;
    logic accept;
    logic out_free;

    // Staged item: held back one step so that the final one can carry tlast.
    logic [7:0] stg_d_reg, stg_d_next;
    logic stg_cv_reg, stg_cv_next;

    logic ov_reg, ov_next;
    logic [7:0] od_reg, od_next;
    kind_t ok_reg, ok_next;
    logic ocv_reg, ocv_next, ol_reg, ol_next;

    // A byte at or past the fill count reads as zero.
    logic in_line;
    logic [7:0] cur;
    logic cont;
    kind_t head_kind;
    logic [7:0] h [5];

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !ov_reg || m_tready;
    assign we = accept && s_tdata != CH_CR && s_tdata != CH_LF
                && fill_reg < FILL_W'(LINE_DEPTH - 1);
    assign raddr = pos_reg[ADDR_W-1:0];
    assign in_line = pos_reg < (ADDR_W+1)'(fill_reg);
    assign cur = in_line ? rdata : 8'd0;

    mrlp_line_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (s_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    function automatic kind_t classify(input logic [7:0] h0, input logic [7:0] h1,
        input logic [7:0] h2, input logic [7:0] h3, input logic [7:0] h4);
        kind_t k;
        k = KIND_OTHER;
        if (h0 == CH_PLUS && h1 == "C" && h2 == "L" && h3 == "I") k = KIND_CALLER;
        else if (h0 == CH_PLUS && h1 == "C" && h2 == "M" && h3 == "T" && h4 == "I")
            k = KIND_SLOT;
        else if (h0 == CH_PLUS && h1 == "C" && h2 == "S" && h3 == "Q") k = KIND_SIGNAL;
        else if (h0 == CH_PLUS && h1 == "C" && h2 == "M" && h3 == "D") k = KIND_CMD;
        else if (h0 == CH_PLUS && h1 == "C" && h2 == "M" && h3 == "G" && h4 == "R")
            k = KIND_SENDER;
        else if (h0 == "O" && h1 == "K") k = KIND_OK;
        return k;
    endfunction

    // The first five bytes are also kept in flops for classification.
    always_ff @(posedge clk)
    begin
        if (we && fill_reg < FILL_W'(5))
        begin
            hdr_reg[fill_reg[2:0]] <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            line_open_reg <= 1'b0;
            pend_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            line_open_reg <= line_open_next;
            pend_reg <= pend_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        pos_reg <= pos_next;
        cnt_reg <= cnt_next;
        stg_d_reg <= stg_d_next;
        stg_cv_reg <= stg_cv_next;
        od_reg <= od_next;
        ok_reg <= ok_next;
        ocv_reg <= ocv_next;
        ol_reg <= ol_next;
    end

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            h[i] = (FILL_W'(i) < fill_reg) ? hdr_reg[i] : 8'd0;
        end
    end

    assign head_kind = classify(h[0], h[1], h[2], h[3], h[4]);

    // Copy continuation test for the byte now read.
    always_comb
    begin
        cont = 1'b0;
        if (in_line)
        begin
            unique case (kind_reg)
                KIND_CALLER, KIND_SENDER:
                    cont = cur != CH_QUOTE && cnt_reg < 5'(NUM_CAP);
                KIND_SLOT:
                    cont = cur >= CH_0 && cur <= CH_9 && cnt_reg < 5'(CHAR_CAP);
                KIND_SIGNAL:
                    cont = cur != CH_COMMA && pos_reg < (ADDR_W+1)'(8);
                KIND_CMD:
                    cont = cur != CH_HASH && cnt_reg < 5'(CHAR_CAP);
                default: cont = 1'b0;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && s_tdata == CH_LF && line_open_reg) state_next = ST_HEAD;
            ST_HEAD:
                if (head_kind == KIND_SENDER) state_next = ST_SEARCH;
                else if (head_kind == KIND_CALLER || head_kind == KIND_SLOT
                         || head_kind == KIND_SIGNAL || head_kind == KIND_CMD)
                    state_next = ST_COPY;
                else state_next = ST_DONE;
            ST_SEARCH:
                if (pend_reg)
                begin
                    if (cur == CH_QUOTE) state_next = ST_COPY;
                    else if (pos_reg == (ADDR_W+1)'(40)) state_next = ST_DONE;
                end
            ST_COPY:
                if (pend_reg && !cont) state_next = ST_DONE;
            ST_DONE:
                if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        fill_next = fill_reg;
        line_open_next = line_open_reg;
        kind_next = kind_reg;
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        pend_next = 1'b1;
        stg_d_next = stg_d_reg;
        stg_cv_next = stg_cv_reg;
        ov_next = ov_reg && !m_tready;
        od_next = od_reg;
        ok_next = ok_reg;
        ocv_next = ocv_reg;
        ol_next = ol_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tdata == CH_CR)
                    begin
                        if (line_open_reg && fill_reg == '0) line_open_next = 1'b0;
                    end
                    else if (s_tdata == CH_LF) line_open_next = !line_open_reg;
                    else if (we) fill_next = fill_reg + FILL_W'(1);
                end
            end
            ST_HEAD:
            begin
                kind_next = head_kind;
                stg_d_next = 8'd0;
                stg_cv_next = 1'b0;
                cnt_next = '0;
                pend_next = 1'b0;
                unique case (head_kind)
                    KIND_CALLER: pos_next = (ADDR_W+1)'(8);
                    KIND_SLOT:   pos_next = (ADDR_W+1)'(12);
                    KIND_SIGNAL: pos_next = (ADDR_W+1)'(6);
                    KIND_CMD:    pos_next = (ADDR_W+1)'(4);
                    default:     pos_next = (ADDR_W+1)'(21);
                endcase
            end
            ST_SEARCH:
            begin
                if (pend_reg && pos_reg != (ADDR_W+1)'(40) || pend_reg && cur == CH_QUOTE)
                begin
                    pend_next = 1'b0;
                    if (cur == CH_QUOTE) pos_next = pos_reg - (ADDR_W+1)'(10);
                    else pos_next = pos_reg + (ADDR_W+1)'(1);
                end
            end
            ST_COPY:
            begin
                if (pend_reg && cont && out_free)
                begin
                    ov_next = 1'b1;
                    od_next = stg_d_reg;
                    ok_next = kind_reg;
                    ocv_next = stg_cv_reg;
                    ol_next = 1'b0;
                    stg_d_next = cur;
                    stg_cv_next = 1'b1;
                    cnt_next = cnt_reg + 5'd1;
                    pos_next = pos_reg + (ADDR_W+1)'(1);
                    pend_next = 1'b0;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    od_next = stg_d_reg;
                    ok_next = kind_reg;
                    ocv_next = stg_cv_reg;
                    ol_next = 1'b1;
                    fill_next = '0;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tdata = od_reg;
    assign m_tuser = {ocv_reg, ok_reg};
    assign m_tlast = ol_reg;

`ifndef ASSERT_OFF
    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !s_tready) else $error("input taken while busy");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FILL_W'(LINE_DEPTH)) else $error("fill count out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))
        else $error("output item changed while waiting");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && !ov_reg |=> state_reg == ST_IDLE)
        else $error("done did not return to idle");
`endif

endmodule

>>> rtl/core/mrlp_line_ram.sv
// Line store: one write port and one read port with a registered read.
// Depends on mrlp_pkg for the depth and address width.
module mrlp_line_ram
    import mrlp_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [LINE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
